// ===== hw/rtl/ptplm_pkg.sv =====
// ptplm_pkg: shared types and constants of the peak-to-peak level meter
// payload structs, controller states, command and status groups
// no dependencies
`default_nettype none

package ptplm_pkg;

  localparam int SampleBits = 12;
  localparam int BarBits    = 8;
  localparam int ProdBits   = SampleBits + BarBits;
  localparam int StepBits   = $clog2(BarBits);

  localparam logic [BarBits-1:0] BarHalfReset = BarBits'(30);

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [SampleBits-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [SampleBits-1:0] amplitude;
    logic [SampleBits-1:0] peak_amplitude;
    logic [BarBits-1:0]    bar_length;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PUT
  } state_e;

  typedef struct packed {
    logic sample_en;
    logic tick_en;
    logic mul_en;
    logic div_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptplm_ctrl.sv =====
// ptplm_ctrl: sequencer of the level meter (idle, multiply, divide, deliver)
// and the output valid flag; depends on ptplm_pkg
`default_nettype none

module ptplm_ctrl
  import ptplm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_command_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_command_i == CmdTick)) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.sample_en = (state_q == ST_IDLE) && accept && (in_command_i == CmdSample);
    cmd_o.tick_en   = (state_q == ST_IDLE) && accept && (in_command_i == CmdTick);
    cmd_o.mul_en    = (state_q == ST_MUL);
    cmd_o.div_en    = (state_q == ST_DIV);
    cmd_o.out_load  = (state_q == ST_PUT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ptplm_dp.sv =====
// ptplm_dp: window min/max tracking, running peak, scale multiply,
// restoring divider and output register; depends on ptplm_pkg
`default_nettype none

module ptplm_dp
  import ptplm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [BarBits-1:0] cfg_data_i,
  input  wire in_t                in_data_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  output out_t                    out_data_o
);

  logic [SampleBits:0]   low_q, low_d;
  logic [SampleBits-1:0] high_q, high_d;
  logic                  seen_q, seen_d;
  logic [SampleBits-1:0] peak_q, peak_d;
  logic [BarBits-1:0]    half_q;
  logic [SampleBits-1:0] amp_q, amp_d;
  logic [SampleBits-1:0] rem_q;
  logic [BarBits-1:0]    quo_q;
  logic [StepBits-1:0]   cnt_q;
  out_t                  out_q;

  logic [ProdBits-1:0]   prod;
  logic [SampleBits:0]   trial;
  logic [SampleBits:0]   diff;
  logic                  qbit;

  // window tracking and peak update
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    seen_d = seen_q;
    peak_d = peak_q;
    amp_d  = amp_q;
    if (cmd_i.sample_en) begin
      if ({1'b0, in_data_i.sample} < low_q) low_d = {1'b0, in_data_i.sample};
      if (in_data_i.sample > high_q) high_d = in_data_i.sample;
      seen_d = 1'b1;
    end else if (cmd_i.tick_en) begin
      amp_d = '0;
      // empty window reports zero instead of wrapping
      if (seen_q && ({1'b0, high_q} >= low_q)) amp_d = high_q - low_q[SampleBits-1:0];
      if (amp_d > peak_q) peak_d = amp_d;
      low_d  = {1'b1, {SampleBits{1'b0}}};
      high_d = '0;
      seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= {1'b1, {SampleBits{1'b0}}};
      high_q <= '0;
      seen_q <= 1'b0;
      peak_q <= '0;
      half_q <= BarHalfReset;
      cnt_q  <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      seen_q <= seen_d;
      peak_q <= peak_d;
      if (cfg_we_i) half_q <= cfg_data_i;
      if (cmd_i.mul_en) cnt_q <= '0;
      else if (cmd_i.div_en) cnt_q <= cnt_q + StepBits'(1);
    end
  end

  assign prod = ProdBits'(half_q) * ProdBits'(amp_q);

  // quotient fits in BarBits since amplitude never exceeds the peak,
  // so the upper product bits start below the divisor
  assign trial = {rem_q, quo_q[BarBits-1]};
  assign diff  = trial - {1'b0, peak_q};
  assign qbit  = (trial >= {1'b0, peak_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_en) amp_q <= amp_d;
    if (cmd_i.mul_en) begin
      rem_q <= prod[ProdBits-1:BarBits];
      quo_q <= prod[BarBits-1:0];
    end else if (cmd_i.div_en) begin
      rem_q <= qbit ? diff[SampleBits-1:0] : trial[SampleBits-1:0];
      quo_q <= {quo_q[BarBits-2:0], qbit};
    end
    if (cmd_i.out_load) begin
      out_q.amplitude      <= amp_q;
      out_q.peak_amplitude <= peak_q;
      out_q.bar_length     <= (peak_q == '0) ? '0 : quo_q;
    end
  end

  assign sts_o.div_last = (cnt_q == StepBits'(BarBits - 1));
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/peak_to_peak_level_meter.sv =====
// peak_to_peak_level_meter: top level, joins controller and datapath
// depends on ptplm_pkg, ptplm_ctrl, ptplm_dp
//
// Input requests (in_valid_i/in_ready_o, in_data_i) carry either a converter
// sample or an end-of-window tick. A sample gives no result; samples stream
// at one per cycle while no tick is in progress. A tick computes the window's
// peak-to-peak amplitude, updates the running peak and scales the bar length
// with an 8-step restoring divider: the tick latches the amplitude, then
// multiplies, runs eight divide steps and loads the output register, and
// in_ready_o is low from the multiply until the load. The result request
// appears on out_valid_o/out_data_o the cycle after the load and stays
// until out_ready_i; while it waits, samples are still accepted, and a
// following tick finishes its divide and then holds until the output
// register frees up. Configuration writes (cfg_valid_i/cfg_ready_o,
// cfg_data_i = bar half length) are always ready. Reset clears the window,
// the running peak and the output valid flag, and sets the half length to 30.
`default_nettype none

module peak_to_peak_level_meter
  import ptplm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [BarBits-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ptplm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  ptplm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  a_amp_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.amplitude <= out_data_o.peak_amplitude))
    else $error("amplitude above running peak");

  a_zero_peak_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.peak_amplitude == '0)) |-> (out_data_o.bar_length == '0))
    else $error("nonzero bar with zero peak");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.command == CmdTick)) |=> !in_ready_o)
    else $error("input taken while tick in progress");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for peak_to_peak_level_meter
// predicts each window reading from its own copy of the meter state and compares it
// depends on ptplm_pkg and the peak_to_peak_level_meter rtl

module testbench;
  import ptplm_pkg::*;

  localparam int SampleMax   = (1 << SampleBits) - 1;
  localparam int DrainCycles = 16;
  localparam int ReportLimit = 10;

  typedef enum int {
    RX_ALWAYS,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready_o;
  logic [BarBits-1:0] cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready_o;
  in_t                in_data     = '0;
  logic               out_valid_o;
  logic               out_ready   = 1'b0;
  out_t               out_data_o;

  // meter state as the block should hold it
  logic [SampleBits:0]   model_low  = 13'(1 << SampleBits);
  logic [SampleBits-1:0] model_high = '0;
  logic                  model_seen = 1'b0;
  logic [SampleBits-1:0] model_peak = '0;
  logic [BarBits-1:0]    model_half = BarHalfReset;

  out_t expected_readings[$];

  int unsigned samples_sent    = 0;
  int unsigned ticks_sent      = 0;
  int unsigned readings_seen   = 0;
  int unsigned half_writes     = 0;
  int unsigned error_count     = 0;

  logic     sender_bursts = 1'b0;
  int       burst_left    = 0;
  rx_mode_e rx_mode       = RX_ALWAYS;
  int       rx_run_left   = 0;

  peak_to_peak_level_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic predict_request(input in_t req);
    out_t        reading;
    int unsigned amp;
    int unsigned bar;
    if (req.command == CmdSample) begin
      if ({1'b0, req.sample} < model_low) model_low = {1'b0, req.sample};
      if (req.sample > model_high) model_high = req.sample;
      model_seen = 1'b1;
      samples_sent++;
    end else begin
      amp = 0;
      if (model_seen && {1'b0, model_high} >= model_low) begin
        amp = int'(model_high) - int'(model_low);
      end
      if (amp > model_peak) model_peak = SampleBits'(amp);
      bar = 0;
      // zero peak means nothing to scale against
      if (model_peak != 0) bar = (int'(model_half) * amp) / int'(model_peak);
      reading.amplitude      = SampleBits'(amp);
      reading.peak_amplitude = model_peak;
      reading.bar_length     = BarBits'(bar);
      expected_readings.push_back(reading);
      model_low  = 13'(1 << SampleBits);
      model_high = '0;
      model_seen = 1'b0;
      ticks_sent++;
    end
  endtask

  task automatic check_reading(input out_t got);
    out_t want;
    readings_seen++;
    if (expected_readings.size() == 0) begin
      error_count++;
      if (error_count <= ReportLimit) begin
        $display("reading %0d arrived with none pending: amp %0d peak %0d bar %0d",
                 readings_seen, got.amplitude, got.peak_amplitude, got.bar_length);
      end
    end else begin
      want = expected_readings.pop_front();
      if (got.amplitude !== want.amplitude || got.peak_amplitude !== want.peak_amplitude ||
          got.bar_length !== want.bar_length) begin
        error_count++;
        if (error_count <= ReportLimit) begin
          $display("reading %0d wrong: expected amp %0d peak %0d bar %0d, got amp %0d peak %0d bar %0d",
                   readings_seen, want.amplitude, want.peak_amplitude, want.bar_length,
                   got.amplitude, got.peak_amplitude, got.bar_length);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (cfg_valid && cfg_ready_o) begin
      model_half = cfg_data;
      half_writes++;
    end
    if (in_valid && in_ready_o) predict_request(in_data);
    if (out_valid_o && out_ready) check_reading(out_data_o);
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (rx_run_left > 0) begin
      rx_run_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_CHOPPY: begin
          out_ready   <= 1'($urandom_range(0, 1));
          rx_run_left = $urandom_range(0, 2);
        end
        default: begin
          out_ready   <= ~out_ready;
          rx_run_left = out_ready ? $urandom_range(3, 20) : $urandom_range(0, 3);
        end
      endcase
    end
  end

  task automatic send_request(input in_t req);
    if (sender_bursts && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_sample(input logic [SampleBits-1:0] value);
    send_request(in_t'{command: CmdSample, sample: value});
  endtask

  task automatic send_tick();
    // sample field is don't-care on a tick, so drive it with noise
    send_request(in_t'{command: CmdTick, sample: SampleBits'($urandom)});
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    // let the monitor log the last accepted request before looking at the queue
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_half_length(input logic [BarBits-1:0] value);
    drain_readings();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_windows(input int n_items, input int span_cap);
    int sent;
    int roll;
    int span;
    int base;
    int len;
    int value;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // empty window, often right after another tick
        send_tick();
        sent++;
      end else if (roll < 12) begin
        len = $urandom_range(1, 6);
        repeat (len) send_sample(SampleBits'($urandom));
        send_tick();
        sent += len + 1;
      end else begin
        span = $urandom_range(0, span_cap);
        base = $urandom_range(0, SampleMax - span);
        len  = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          if (i == 0 && roll < 60) value = base;
          else if (i == len - 1 && roll < 60) value = base + span;
          else value = base + $urandom_range(0, span);
          send_sample(SampleBits'(value));
        end
        send_tick();
        sent += len + 1;
      end
    end
  endtask

  task automatic test_empty_and_single();
    // zero peak: nothing seen yet, so the bar reads zero
    send_tick();
    send_sample(12'd2048);
    send_tick();
  endtask

  task automatic test_sample_bit_patterns();
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_tick();
    send_sample(12'hFFF);
    send_tick();
    send_sample(12'h000);
    send_tick();
  endtask

  task automatic test_peak_growth();
    // smaller window under an old peak, then a new peak
    send_sample(12'd100);
    send_sample(12'd150);
    send_tick();
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_tick();
  endtask

  task automatic test_half_length_extremes();
    write_half_length(8'd0);
    send_sample(12'd5);
    send_sample(12'd2005);
    send_tick();
    write_half_length(8'd255);
    send_sample(12'd5);
    send_sample(12'd2005);
    send_tick();
    write_half_length(8'd1);
    send_sample(12'd10);
    send_sample(12'd1010);
    send_tick();
  endtask

  task automatic test_random_steady();
    write_half_length(8'd77);
    sender_bursts = 1'b0;
    rx_mode       = RX_ALWAYS;
    run_random_windows(310, 300);
  endtask

  task automatic test_random_unit_half();
    write_half_length(8'd1);
    sender_bursts = 1'b1;
    rx_mode       = RX_CHOPPY;
    run_random_windows(310, 1200);
  endtask

  task automatic test_random_full_half();
    write_half_length(8'd255);
    sender_bursts = 1'b1;
    rx_mode       = RX_SLOW;
    run_random_windows(310, 2500);
  endtask

  task automatic test_random_any_half();
    write_half_length(BarBits'($urandom_range(0, 255)));
    sender_bursts = 1'b1;
    rx_mode       = RX_CHOPPY;
    run_random_windows(310, SampleMax);
  endtask

  task automatic test_full_scale();
    write_half_length(BarHalfReset);
    sender_bursts = 1'b0;
    rx_mode       = RX_SLOW;
    send_sample(12'd0);
    send_sample(12'd4095);
    send_tick();
    send_tick();
    send_sample(12'd2048);
    send_sample(12'd2049);
    send_tick();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_single();
    test_sample_bit_patterns();
    test_peak_growth();
    test_half_length_extremes();
    test_random_steady();
    test_random_unit_half();
    test_random_full_half();
    test_random_any_half();
    test_full_scale();
    drain_readings();
    $display("ran %0d samples and %0d window ticks, %0d readings compared",
             samples_sent, ticks_sent, readings_seen);
    $display("bar half length written %0d times, %0d errors found", half_writes, error_count);
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("run timed out with %0d readings pending", expected_readings.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ptplm_pkg.sv
hw/rtl/ptplm_ctrl.sv
hw/rtl/ptplm_dp.sv
hw/rtl/peak_to_peak_level_meter.sv
dv/testbench.sv
